// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
// Needs no package; the clock and reset are passed in by the user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define TWM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Checked on every clock edge, reset included.
`define TWM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ===== rtl/core/twm_pkg.sv =====
// Package of the trimmed window mean core: sizes, types and codes.
// Used by the interfaces, the cells, the divider and the top level.
`timescale 1ns / 1ps
package twm_pkg;

    localparam int WINDOW_DEPTH = 16;
    localparam int IDX_W        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    // sum of WINDOW_DEPTH signed 16-bit values, with one spare bit
    localparam int SUM_W        = 16 + IDX_W + 1;
    localparam int DIST_W       = SUM_W + 1;
    localparam logic [15:0] MAX_AGE_RST = 16'd4000;

    typedef struct packed {
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] yaw_rate;
        logic [31:0]        stamp;
    } t_cell_data;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ZERO,
        CELL_SHIFT,
        CELL_ROT
    } t_cell_op;

    typedef struct packed {
        t_cell_op    op;
        logic [31:0] now;
        logic [15:0] max_age;
    } t_cell_ctl;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DROP,
        ST_INSERT,
        ST_SUM,
        ST_DIST,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DONE
    } t_state;

    // channel c of a cell entry: 0 forward, 1 sideways, 2 turn rate
    function automatic logic signed [15:0] chan(input t_cell_data d, input logic [1:0] c);
        logic signed [15:0] v;
        case (c)
            2'd0:    v = d.vel_x;
            2'd1:    v = d.vel_y;
            default: v = d.yaw_rate;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/twm_ifs.sv =====
// Valid/ready channel interfaces of the trimmed window mean core.
// Depends on twm_pkg for the count width.
`timescale 1ns / 1ps
interface twm_in_if;
    logic               valid;
    logic               ready;
    logic [31:0]        timestamp;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] yaw_rate;

    modport source (output valid, timestamp, vel_x, vel_y, yaw_rate, input ready);
    modport sink   (input valid, timestamp, vel_x, vel_y, yaw_rate, output ready);
endinterface

interface twm_out_if;
    logic                       valid;
    logic                       ready;
    logic signed [15:0]         mean_x;
    logic signed [15:0]         mean_y;
    logic signed [15:0]         mean_yaw;
    logic [twm_pkg::CNT_W-1:0]  window_count;

    modport source (output valid, mean_x, mean_y, mean_yaw, window_count, input ready);
    modport sink   (input valid, mean_x, mean_y, mean_yaw, window_count, output ready);
endinterface

// ===== rtl/core/twm_cell.sv =====
// One window cell: holds a sample and its stamp, shifts or rotates with neighbors.
// Depends on twm_pkg.
`timescale 1ns / 1ps
module twm_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  twm_pkg::t_cell_ctl  i_ctl,
    input  twm_pkg::t_cell_data i_prev,
    input  twm_pkg::t_cell_data i_next,
    output twm_pkg::t_cell_data o_data,
    output logic                o_expired
);
    import twm_pkg::*;

    t_cell_data  r_data;
    t_cell_data  n_data;
    logic [31:0] age;

    // next entry by operation
    always_comb begin
        case (i_ctl.op)
            CELL_ZERO:  n_data = '{vel_x: '0, vel_y: '0, yaw_rate: '0, stamp: i_ctl.now};
            CELL_SHIFT: n_data = i_prev;
            CELL_ROT:   n_data = i_next;
            default:    n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else begin
            r_data <= n_data;
        end
    end

    // age wraps modulo 2^32
    assign age       = i_ctl.now - r_data.stamp;
    assign o_expired = age >= {16'd0, i_ctl.max_age};
    assign o_data    = r_data;

endmodule

// ===== rtl/core/twm_div.sv =====
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on twm_pkg for operand widths.
`timescale 1ns / 1ps
module twm_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [twm_pkg::SUM_W-1:0]  i_dividend,
    input  logic [twm_pkg::CNT_W-1:0]         i_divisor,
    output logic                              o_done,
    output logic signed [15:0]                o_quot
);
    import twm_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [SUM_W-1:0]  r_q;
    logic [CNT_W:0]    r_rem;
    logic [CNT_W-1:0]  r_div;
    logic              r_neg;
    logic [CNT_W:0]    rem_sh;
    logic              ge;
    logic [SUM_W-1:0]  mag;
    logic [SUM_W-1:0]  q_signed;

    assign mag    = i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);
    assign rem_sh = {r_rem[CNT_W-1:0], r_q[SUM_W-1]};
    assign ge     = rem_sh >= {1'b0, r_div};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: restoring step on magnitudes
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= mag;
            r_rem <= '0;
            r_div <= i_divisor;
            r_neg <= i_dividend[SUM_W-1];
        end else if (r_busy) begin
            r_rem <= ge ? rem_sh - {1'b0, r_div} : rem_sh;
            r_q   <= {r_q[SUM_W-2:0], ge};
        end
    end

    assign q_signed = r_neg ? -r_q : r_q;
    assign o_quot   = q_signed[15:0];
    assign o_done   = r_done;

endmodule

// ===== rtl/core/timed_window_trimmed_mean_core.sv =====
// Trimmed moving average of timestamped velocity commands.
// Top level; depends on twm_pkg, twm_ifs, twm_cell and twm_div.
//
// Channels: i_in carries one command item (timestamp, vel_x, vel_y,
// yaw_rate) and o_out one result item (mean_x, mean_y, mean_yaw,
// window_count); both are valid/ready, an item moves when both are high.
// i_cfg_we / i_cfg_wdata write max_age; write it only while the core is idle.
// The window is a row of WINDOW_DEPTH cells ordered newest first. New items
// shift in at cell 0; the sum and outlier passes rotate the row one full
// turn each, reading cell 0. Three serial dividers then form the means.
// Per item the core checks for expired samples, drops them from the oldest
// end (or zeroes the whole row when all have expired), shifts the new item
// in, then runs the sum and outlier passes and the bit-serial dividers.
// One item is worked on at a time; i_in.ready is high only between items.
// The result sits in an output register: while the receiver stalls, the core
// still accepts and processes the next item, then waits with it finished.
// Reset (synchronous, active low) fills the window with sixteen zero samples
// stamped zero and sets max_age to 4000; no clearing pass is needed.
`timescale 1ns / 1ps
module timed_window_trimmed_mean_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    twm_in_if.sink           i_in,
    twm_out_if.source        o_out,
    input  logic             i_cfg_we,
    input  logic [15:0]      i_cfg_wdata
);
    import twm_pkg::*;

    t_state             r_state, n_state;
    logic [15:0]        r_max_age;
    logic [31:0]        r_now;
    logic signed [15:0] r_new [3];
    logic [CNT_W-1:0]   r_fill;
    logic [IDX_W-1:0]   r_j;
    logic signed [SUM_W-1:0] r_sum [3];
    logic [DIST_W-1:0]  r_best_d [3];
    logic signed [15:0] r_best_v [3];
    logic               r_ov;
    logic signed [15:0] r_mean [3];
    logic [CNT_W-1:0]   r_cnt_out;

    t_cell_ctl          cell_ctl;
    t_cell_op           cell_op;
    t_cell_data         cell_q [WINDOW_DEPTH];
    t_cell_data         new_data;
    logic [WINDOW_DEPTH-1:0] cell_exp;
    logic               all_old;
    logic               j_in;
    logic               j_last;
    logic               div_start;
    logic               div_done [3];
    logic signed [15:0] div_q [3];
    logic [IDX_W-1:0]   drop_idx;
    logic               out_free;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_age <= MAX_AGE_RST;
        end else if (i_cfg_we) begin
            r_max_age <= i_cfg_wdata;
        end
    end

    assign new_data = '{vel_x: r_new[0], vel_y: r_new[1], yaw_rate: r_new[2], stamp: r_now};
    assign cell_ctl = '{op: cell_op, now: r_now, max_age: r_max_age};

    // row of cells, newest in cell 0
    for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
        twm_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (cell_ctl),
            .i_prev    ((k == 0) ? new_data : cell_q[(k + WINDOW_DEPTH - 1) % WINDOW_DEPTH]),
            .i_next    (cell_q[(k + 1) % WINDOW_DEPTH]),
            .o_data    (cell_q[k]),
            .o_expired (cell_exp[k])
        );
    end

    // all live samples expired (empty window counts as expired)
    always_comb begin
        all_old = 1'b1;
        for (int k = 0; k < WINDOW_DEPTH; k++) begin
            if ((CNT_W'(k) < r_fill) && !cell_exp[k]) begin
                all_old = 1'b0;
            end
        end
    end

    assign drop_idx = IDX_W'(r_fill - 1'b1);
    assign j_in     = CNT_W'(r_j) < r_fill;
    assign j_last   = r_j == IDX_W'(WINDOW_DEPTH - 1);
    assign out_free = !r_ov || o_out.ready;

    // next state and cell control
    always_comb begin
        n_state   = r_state;
        cell_op   = CELL_HOLD;
        div_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (all_old) begin
                    cell_op = CELL_ZERO;
                    n_state = ST_INSERT;
                end else begin
                    n_state = ST_DROP;
                end
            end
            ST_DROP: begin
                if (r_fill == '0 || !cell_exp[drop_idx]) n_state = ST_INSERT;
            end
            ST_INSERT: begin
                cell_op = CELL_SHIFT;
                n_state = ST_SUM;
            end
            ST_SUM: begin
                cell_op = CELL_ROT;
                if (j_last) n_state = ST_DIST;
            end
            ST_DIST: begin
                cell_op = CELL_ROT;
                if (j_last) n_state = (r_fill == CNT_W'(1)) ? ST_DONE : ST_DIV_START;
            end
            ST_DIV_START: begin
                div_start = 1'b1;
                n_state   = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done[0] && div_done[1] && div_done[2]) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign i_in.ready = r_state == ST_IDLE;

    // fill count and pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= CNT_W'(WINDOW_DEPTH);
            r_j    <= '0;
        end else begin
            case (r_state)
                ST_CHECK: begin
                    if (all_old) r_fill <= CNT_W'(WINDOW_DEPTH);
                end
                ST_DROP: begin
                    if (r_fill != '0 && cell_exp[drop_idx]) r_fill <= r_fill - 1'b1;
                end
                ST_INSERT: begin
                    if (r_fill < CNT_W'(WINDOW_DEPTH)) r_fill <= r_fill + 1'b1;
                    r_j <= '0;
                end
                ST_SUM, ST_DIST: begin
                    r_j <= j_last ? '0 : r_j + 1'b1;
                end
                default: r_j <= r_j;
            endcase
        end
    end

    // captured item, sums and outlier search
    always_ff @(posedge i_clk) begin
        logic signed [15:0]       x;
        logic signed [SUM_W-1:0]  prod;
        logic signed [DIST_W-1:0] diff;
        logic [DIST_W-1:0]        dev_abs;
        if (i_in.valid && i_in.ready) begin
            r_now    <= i_in.timestamp;
            r_new[0] <= i_in.vel_x;
            r_new[1] <= i_in.vel_y;
            r_new[2] <= i_in.yaw_rate;
        end
        for (int c = 0; c < 3; c++) begin
            x       = chan(cell_q[0], 2'(c));
            prod    = SUM_W'($signed({1'b0, r_fill})) * SUM_W'(x);
            diff    = DIST_W'(r_sum[c]) - DIST_W'(prod);
            dev_abs = diff[DIST_W-1] ? DIST_W'(-diff) : DIST_W'(diff);
            case (r_state)
                ST_INSERT: r_sum[c] <= '0;
                ST_SUM: begin
                    if (j_in) r_sum[c] <= r_sum[c] + SUM_W'(x);
                end
                ST_DIST: begin
                    if (r_j == '0 || (j_in && dev_abs > r_best_d[c])) begin
                        r_best_d[c] <= dev_abs;
                        r_best_v[c] <= x;
                    end
                end
                default: r_sum[c] <= r_sum[c];
            endcase
        end
    end

    // one serial divider per channel
    for (genvar c = 0; c < 3; c++) begin : g_div
        twm_div u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (div_start),
            .i_dividend (r_sum[c] - SUM_W'(r_best_v[c])),
            .i_divisor  (CNT_W'(r_fill - 1'b1)),
            .o_done     (div_done[c]),
            .o_quot     (div_q[c])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            for (int c = 0; c < 3; c++) begin
                r_mean[c] <= (r_fill == CNT_W'(1)) ? r_sum[c][15:0] : div_q[c];
            end
            r_cnt_out <= r_fill;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.mean_x       = r_mean[0];
    assign o_out.mean_y       = r_mean[1];
    assign o_out.mean_yaw     = r_mean[2];
    assign o_out.window_count = r_cnt_out;

endmodule

// ===== rtl/core/twm_chk.sv =====
// Port-level checker of the trimmed window mean core, bound to the top level.
// Depends on assert_macros.svh and twm_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module twm_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [15:0]                i_mean_x,
    input logic [twm_pkg::CNT_W-1:0]  i_count
);
    import twm_pkg::*;

    `TWM_ASSERT(a_count_range, i_clk, i_rst_n, i_out_valid |-> (i_count != '0 && i_count <= CNT_W'(WINDOW_DEPTH)))
    `TWM_ASSERT(a_no_out_after_reset, i_clk, i_rst_n, $rose(i_rst_n) |-> !i_out_valid)
    `TWM_ASSERT(a_ready_drops_on_accept, i_clk, i_rst_n, (i_in_valid && i_in_ready) |=> !i_in_ready)
    `TWM_ASSERT(a_hold_stalled, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_mean_x)))

endmodule

bind timed_window_trimmed_mean_core twm_chk u_twm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_mean_x    (o_out.mean_x),
    .i_count     (o_out.window_count)
);
